@@ sv/ethf_pkg.sv @@
// Shared types and constants for the Ethernet/IPv4/TCP header filter.
// Used by ethf_capture, ethf_judge and eth_ipv4_tcp_header_filter; no dependencies.
package ethf_pkg;

	localparam logic [6:0]  ETH_HDR_BYTES = 7'd14;
	localparam logic [15:0] IPV4_TYPE     = 16'h0800;
	localparam logic [7:0]  TCP_PROTO     = 8'd6;
	localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;

	localparam logic [3:0] VERDICT_MATCH_PAYLOAD = 4'd0;
	localparam logic [3:0] VERDICT_MATCH_EMPTY   = 4'd1;
	localparam logic [3:0] VERDICT_SHORT_ETH     = 4'd2;
	localparam logic [3:0] VERDICT_NOT_IPV4      = 4'd3;
	localparam logic [3:0] VERDICT_IP_INCOMPLETE = 4'd4;
	localparam logic [3:0] VERDICT_SRC_MISMATCH  = 4'd5;
	localparam logic [3:0] VERDICT_NOT_TCP       = 4'd6;
	localparam logic [3:0] VERDICT_TCP_INCOMPL   = 4'd7;
	localparam logic [3:0] VERDICT_PORT_MISMATCH = 4'd8;
	localparam logic [3:0] VERDICT_MALFORMED_LEN = 4'd9;

	localparam logic [1:0] CFG_SRC_ADDR = 2'd0;
	localparam logic [1:0] CFG_SRC_PORT = 2'd1;
	localparam logic [1:0] CFG_DST_PORT = 2'd2;

	localparam int OUT_W = 112;

	typedef struct packed {
		logic [15:0] ether_type;
		logic [3:0]  ip_header_words;
		logic [15:0] ip_total_length;
		logic [7:0]  ip_protocol;
		logic [31:0] source_address;
		logic [31:0] ports;
		logic [3:0]  tcp_offset_words;
	} frame_t;

	typedef struct packed {
		logic [31:0] source_address;
		logic [15:0] source_port;
		logic [15:0] destination_port;
	} cfg_t;

endpackage

@@ sv/ethf_capture.sv @@
// Per-byte header capture registers and the end-of-frame snapshot register.
// Depends on ethf_pkg.
module ethf_capture #(
	parameter int MAX_FRAME_BYTES = 2048,
	parameter int CW = $clog2(MAX_FRAME_BYTES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        frame_byte,
	input  logic              last_byte,
	input  logic              advance,
	output logic              valid_s1,
	output ethf_pkg::frame_t  frame_s1,
	output logic [CW-1:0]     len_s1
);

	logic [CW-1:0]    idx_q;
	ethf_pkg::frame_t cur_q;
	ethf_pkg::frame_t nxt;
	logic [CW-1:0]    idx_nxt;
	logic             in_range;
	logic [6:0]       tcp_start;
	logic [CW-1:0]    rel;
	logic             v_s1_q;

	always_comb begin
		nxt       = cur_q;
		in_range  = idx_q < CW'(MAX_FRAME_BYTES);
		idx_nxt   = in_range ? idx_q + CW'(1) : idx_q;
		tcp_start = ethf_pkg::ETH_HDR_BYTES + {1'b0, cur_q.ip_header_words, 2'b00};
		rel       = idx_q - CW'(tcp_start);
		if (in_range) begin
			if (idx_q == CW'(12) || idx_q == CW'(13)) begin
				nxt.ether_type = {cur_q.ether_type[7:0], frame_byte};
			end else if (idx_q == CW'(14)) begin
				nxt.ip_header_words = frame_byte[3:0];
			end else if (idx_q == CW'(16) || idx_q == CW'(17)) begin
				nxt.ip_total_length = {cur_q.ip_total_length[7:0], frame_byte};
			end else if (idx_q == CW'(23)) begin
				nxt.ip_protocol = frame_byte;
			end else if (idx_q >= CW'(26) && idx_q <= CW'(29)) begin
				nxt.source_address = {cur_q.source_address[23:0], frame_byte};
			end
			if (idx_q >= CW'(15) && idx_q >= CW'(tcp_start)) begin
				if (rel <= CW'(3)) begin
					nxt.ports = {cur_q.ports[23:0], frame_byte};
				end else if (rel == CW'(12)) begin
					nxt.tcp_offset_words = frame_byte[7:4];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			cur_q  <= '0;
			v_s1_q <= 1'b0;
		end else begin
			if (accept) begin
				if (last_byte) begin
					idx_q <= '0;
					cur_q <= '0;
				end else begin
					idx_q <= idx_nxt;
					cur_q <= nxt;
				end
			end
			if (accept && last_byte) begin
				v_s1_q <= 1'b1;
			end else if (advance) begin
				v_s1_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_byte) begin
			frame_s1 <= nxt;
			len_s1   <= idx_nxt;
		end
	end

	assign valid_s1 = v_s1_q;

endmodule

@@ sv/ethf_judge.sv @@
// End-of-frame checks on the captured headers and the result output register.
// Depends on ethf_pkg.
module ethf_judge #(
	parameter int CW = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  ethf_pkg::frame_t  frame_s1,
	input  logic [CW-1:0]     len_s1,
	input  ethf_pkg::cfg_t    cfg,
	input  logic              advance,
	output logic              out_valid,
	output logic [ethf_pkg::OUT_W-1:0] out_data
);

	localparam int LW = (CW > 8) ? CW : 8;

	logic [LW-1:0] len;
	logic [6:0]    ip_end;
	logic [7:0]    tcp_end;
	logic [7:0]    hdrs;
	logic [3:0]    verdict;
	logic [10:0]   pay_off;
	logic [15:0]   pay_len;
	logic [15:0]   diff;
	logic          m_tvalid_q;

	always_comb begin
		len     = LW'(len_s1);
		ip_end  = ethf_pkg::ETH_HDR_BYTES + {1'b0, frame_s1.ip_header_words, 2'b00};
		tcp_end = {1'b0, ip_end} + {2'b00, frame_s1.tcp_offset_words, 2'b00};
		hdrs    = {2'b00, frame_s1.ip_header_words, 2'b00}
			+ {2'b00, frame_s1.tcp_offset_words, 2'b00};
		diff    = frame_s1.ip_total_length - {8'd0, hdrs};
		pay_off = '0;
		pay_len = '0;
		if (len < LW'(ethf_pkg::ETH_HDR_BYTES + 7'd1)) begin
			verdict = ethf_pkg::VERDICT_SHORT_ETH;
		end else if (frame_s1.ether_type != ethf_pkg::IPV4_TYPE) begin
			verdict = ethf_pkg::VERDICT_NOT_IPV4;
		end else if (frame_s1.ip_header_words < ethf_pkg::MIN_HDR_WORDS
				|| len < LW'(ip_end)) begin
			verdict = ethf_pkg::VERDICT_IP_INCOMPLETE;
		end else if (frame_s1.source_address != cfg.source_address) begin
			verdict = ethf_pkg::VERDICT_SRC_MISMATCH;
		end else if (frame_s1.ip_protocol != ethf_pkg::TCP_PROTO) begin
			verdict = ethf_pkg::VERDICT_NOT_TCP;
		end else if (frame_s1.tcp_offset_words < ethf_pkg::MIN_HDR_WORDS
				|| len < LW'(tcp_end)) begin
			verdict = ethf_pkg::VERDICT_TCP_INCOMPL;
		end else if (frame_s1.ports[31:16] != cfg.source_port
				|| frame_s1.ports[15:0] != cfg.destination_port) begin
			verdict = ethf_pkg::VERDICT_PORT_MISMATCH;
		end else if (frame_s1.ip_total_length < {8'd0, hdrs}) begin
			verdict = ethf_pkg::VERDICT_MALFORMED_LEN;
		end else begin
			pay_off = {3'b000, tcp_end};
			pay_len = diff;
			verdict = (diff != 16'd0) ? ethf_pkg::VERDICT_MATCH_PAYLOAD
				: ethf_pkg::VERDICT_MATCH_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data <= {1'b0, pay_len, pay_off, frame_s1.ports[15:0],
				frame_s1.ports[31:16], frame_s1.source_address,
				frame_s1.ether_type, verdict};
		end
	end

	assign out_valid = m_tvalid_q;

endmodule

@@ sv/eth_ipv4_tcp_header_filter.sv @@
// The last byte loads the snapshot register; the verdict then loads the output register.
// Throughput: one byte per cycle when not stalled; the capture registers update per byte.
// The input stalls only while the snapshot register and the output register are both full.
// Reset clears capture state but not the snapshot data; loads default address and ports.
// Top level; instantiates ethf_capture and ethf_judge, depends on ethf_pkg.
module eth_ipv4_tcp_header_filter #(
	parameter int MAX_FRAME_BYTES = 2048
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // [7:0] frame_byte
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [3:0] verdict, [19:4] ether_type, [51:20] source_address, [67:52] source_port,
	// [83:68] destination_port, [94:84] payload_offset, [110:95] payload_length
	output logic [111:0] m_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

	ethf_pkg::cfg_t   cfg_q;
	ethf_pkg::frame_t frame_s1;
	logic [CW-1:0]    len_s1;
	logic             valid_s1;
	logic             advance;
	logic             accept;

	assign advance  = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_address   <= 32'hC0A8E980;
			cfg_q.source_port      <= 16'd80;
			cfg_q.destination_port <= 16'd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ethf_pkg::CFG_SRC_ADDR: cfg_q.source_address   <= cfg_data;
				ethf_pkg::CFG_SRC_PORT: cfg_q.source_port      <= cfg_data[15:0];
				ethf_pkg::CFG_DST_PORT: cfg_q.destination_port <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	ethf_capture #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES),
		.CW(CW)
	) u_capture (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.frame_byte(s_tdata),
		.last_byte(s_tlast),
		.advance(advance),
		.valid_s1(valid_s1),
		.frame_s1(frame_s1),
		.len_s1(len_s1)
	);

	ethf_judge #(
		.CW(CW)
	) u_judge (
		.clk(clk),
		.arst_n(arst_n),
		.valid_s1(valid_s1),
		.frame_s1(frame_s1),
		.len_s1(len_s1),
		.cfg(cfg_q),
		.advance(advance),
		.out_valid(m_tvalid),
		.out_data(m_tdata)
	);

	a_fail_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3:0] != ethf_pkg::VERDICT_MATCH_PAYLOAD
			&& m_tdata[3:0] != ethf_pkg::VERDICT_MATCH_EMPTY
		|-> m_tdata[94:84] == 11'd0 && m_tdata[110:95] == 16'd0)
		else $error("payload fields set on a rejected frame");

	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3:0] == ethf_pkg::VERDICT_MATCH_PAYLOAD
		|-> m_tdata[110:95] != 16'd0)
		else $error("match with payload reports zero length");

	a_stall_only_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	a_frame_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tlast |=> valid_s1)
		else $error("frame end did not load the snapshot stage");

endmodule
